>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the slot handle table.
// Each macro wraps one clocked concurrent assertion that is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SHT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sht_pkg.sv
// Package for the slot handle table: field widths, default sizes and codes.
// It has no dependencies; both RTL modules of the block import it.
package sht_pkg;

   // Default table geometry.
   localparam int SLOTS_DEF      = 64;
   localparam int VALUE_BITS_DEF = 32;

   // Fixed field widths of the request and response transfers.
   localparam int ACTION_BITS = 3;
   localparam int SLOT_BITS   = 8;
   localparam int ENTRY_BITS  = 32;
   localparam int COUNT_BITS  = 7;
   localparam int STATUS_BITS = 2;

   // The free-slot search looks at the occupancy map in groups of this size.
   localparam int GROUP_BITS     = 8;
   localparam int GROUP_IDX_BITS = 3;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_ADD     = 3'd0,
      ACT_REMOVE  = 3'd1,
      ACT_REPLACE = 3'd2,
      ACT_LOOKUP  = 3'd3,
      ACT_FIND    = 3'd4
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_USED  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

>>> rtl/core/sht_free_find.sv
// Two-level search for the lowest empty slot in the occupancy map.
// Depends on sht_pkg for the group size.
module sht_free_find #(
   parameter int SLOTS    = sht_pkg::SLOTS_DEF,
   parameter int CNT_BITS = $clog2(SLOTS + 1)
) (
   input  logic                clock,
   input  logic                load,
   input  logic [SLOTS-1:0]    used_map,
   output logic [CNT_BITS-1:0] free_slot
);
   import sht_pkg::*;

   localparam int Groups  = (SLOTS + GROUP_BITS - 1) / GROUP_BITS;
   localparam int PadBits = Groups * GROUP_BITS;

   logic [PadBits-1:0]        padded_map;
   logic [Groups-1:0]         grp_free_in;
   logic [GROUP_IDX_BITS-1:0] grp_low_in [Groups];
   logic [Groups-1:0]         grp_free_ff;
   logic [GROUP_IDX_BITS-1:0] grp_low_ff [Groups];

   // First level: per group, whether any slot is empty and the lowest empty one.
   // Slots past the end of the table count as used.
   always_comb begin
      padded_map              = '1;
      padded_map[SLOTS-1:0]   = used_map;
      for (int g = 0; g < Groups; g++) begin
         grp_free_in[g] = ~&padded_map[g*GROUP_BITS +: GROUP_BITS];
         grp_low_in[g]  = '0;
         for (int b = GROUP_BITS - 1; b >= 0; b--) begin
            if (!padded_map[g*GROUP_BITS + b]) begin
               grp_low_in[g] = GROUP_IDX_BITS'(b);
            end
         end
      end
   end

   // The group results are registered while the slot memory is read.
   always_ff @(posedge clock) begin
      if (load) begin
         grp_free_ff <= grp_free_in;
         grp_low_ff  <= grp_low_in;
      end
   end

   // Second level: the lowest group with an empty slot wins; none means full.
   always_comb begin
      free_slot = CNT_BITS'(SLOTS);
      for (int g = Groups - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            free_slot = CNT_BITS'(g * GROUP_BITS) + CNT_BITS'(grp_low_ff[g]);
         end
      end
   end

endmodule

>>> rtl/core/slot_handle_table.sv
// Top level of the slot handle table: slot memory, occupancy map and count.
// Depends on sht_pkg, sht_free_find and assert_macros.svh.
//
// Usage:
// A request transfer on the req_ channel carries an action (add, remove,
// replace, lookup, find lowest free slot), a slot number and a value. Each
// request produces exactly one response transfer on the rsp_ channel with the
// old slot content, the lowest free slot for find requests, the occupied
// count after the request and a status code.
// One request is in work at a time: the slot memory is read at the request
// transfer and written back in the execute cycle, and no new request is taken
// until that cycle completes. The free-slot search runs alongside the read as
// a registered two-level priority encoder over the occupancy flags. A finished
// response waits in the output register while the next request is taken. If
// rsp_stall holds that response, the following request waits in the execute
// cycle until the output register frees. Reset clears the occupancy flags and
// count; the slot memory is not swept, since an unoccupied slot always reads
// as zero.
`include "assert_macros.svh"

module slot_handle_table #(
   parameter int SLOTS      = sht_pkg::SLOTS_DEF,
   parameter int VALUE_BITS = sht_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sht_pkg::ACTION_BITS-1:0] req_action,
   input  logic [sht_pkg::SLOT_BITS-1:0]   req_slot,
   input  logic [sht_pkg::ENTRY_BITS-1:0]  req_entry_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sht_pkg::ENTRY_BITS-1:0]  rsp_old_value,
   output logic [sht_pkg::COUNT_BITS-1:0]  rsp_free_slot,
   output logic [sht_pkg::COUNT_BITS-1:0]  rsp_occupied,
   output logic [sht_pkg::STATUS_BITS-1:0] rsp_status
);
   import sht_pkg::*;

   localparam int IdxBits   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CntBits   = $clog2(SLOTS + 1);
   localparam int StoreBits = (VALUE_BITS < ENTRY_BITS) ? VALUE_BITS : ENTRY_BITS;

   // Control state.
   state_type                state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SLOTS-1:0]         used_map_ff, used_map_in;
   logic [CntBits-1:0]       used_total_ff, used_total_in;

   // Captured request and memory read data.
   action_type               act_ff;
   logic [SLOT_BITS-1:0]     slot_ff;
   logic [StoreBits-1:0]     entry_ff;
   logic [StoreBits-1:0]     mem_q_ff;
   logic [StoreBits-1:0]     slot_mem [SLOTS];

   // Response registers.
   logic [ENTRY_BITS-1:0]    old_value_ff, old_value_in;
   logic [COUNT_BITS-1:0]    free_slot_ff, free_slot_in;
   logic [COUNT_BITS-1:0]    occupied_ff, occupied_in;
   status_type               status_ff, status_in;

   // Execute-cycle signals.
   logic                     req_xfer;
   logic                     done;
   logic [IdxBits-1:0]       exec_idx;
   logic                     in_range;
   logic                     was_used;
   logic                     now_used;
   logic [StoreBits-1:0]     cur_value;
   logic                     wr_en;
   logic [StoreBits-1:0]     wr_value;
   logic [CntBits-1:0]       found_slot;

   assign req_xfer = req_valid && !req_stall;

   // Lowest free slot, searched while the memory is read.
   sht_free_find #(
      .SLOTS    (SLOTS),
      .CNT_BITS (CntBits)
   ) u_free_find (
      .clock     (clock),
      .load      (req_xfer),
      .used_map  (used_map_ff),
      .free_slot (found_slot)
   );

   // Slot memory: read at the request transfer, written back in the execute cycle.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mem_q_ff <= slot_mem[req_slot[IdxBits-1:0]];
      end
      if (wr_en) begin
         slot_mem[exec_idx] <= wr_value;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         act_ff   <= action_type'(req_action);
         slot_ff  <= req_slot;
         entry_ff <= req_entry_value[StoreBits-1:0];
      end
   end

   // Execute: decode the action against the current slot content.
   always_comb begin
      exec_idx      = slot_ff[IdxBits-1:0];
      in_range      = {1'b0, slot_ff} < (SLOT_BITS + 1)'(SLOTS);
      was_used      = used_map_ff[exec_idx];
      cur_value     = was_used ? mem_q_ff : '0;
      done          = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
      wr_en         = 1'b0;
      wr_value      = '0;
      old_value_in  = '0;
      free_slot_in  = '0;
      status_in     = STAT_OK;

      case (act_ff)
         ACT_ADD: begin
            if (!in_range) begin
               status_in = STAT_RANGE;
            end else if (was_used) begin
               old_value_in = ENTRY_BITS'(cur_value);
               status_in    = STAT_USED;
            end else begin
               wr_en    = 1'b1;
               wr_value = entry_ff;
            end
         end
         ACT_REMOVE: begin
            if (!in_range) begin
               status_in = STAT_RANGE;
            end else begin
               old_value_in = ENTRY_BITS'(cur_value);
               wr_en        = 1'b1;
            end
         end
         ACT_REPLACE: begin
            if (!in_range) begin
               status_in = STAT_RANGE;
            end else begin
               old_value_in = ENTRY_BITS'(cur_value);
               wr_en        = 1'b1;
               wr_value     = entry_ff;
            end
         end
         ACT_LOOKUP: begin
            if (!in_range) begin
               status_in = STAT_RANGE;
            end else begin
               old_value_in = ENTRY_BITS'(cur_value);
            end
         end
         ACT_FIND: begin
            free_slot_in = COUNT_BITS'(found_slot);
         end
         default: begin
         end
      endcase

      // Writes only land when the response can be loaded.
      wr_en    = wr_en && done;
      now_used = (wr_value != '0);

      // Occupancy flag and count follow the written value.
      used_map_in   = used_map_ff;
      used_total_in = used_total_ff;
      if (wr_en) begin
         used_map_in[exec_idx] = now_used;
         if (now_used && !was_used) begin
            used_total_in = used_total_ff + CntBits'(1);
         end else if (was_used && !now_used) begin
            used_total_in = used_total_ff - CntBits'(1);
         end
      end
      occupied_in = COUNT_BITS'(used_total_in);
   end

   // Sequencer and response handshake.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      req_stall    = (state_ff != ST_IDLE);
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         used_map_ff   <= '0;
         used_total_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         used_map_ff   <= used_map_in;
         used_total_ff <= used_total_in;
      end
   end

   // Response registers load when the execute cycle completes.
   always_ff @(posedge clock) begin
      if (done) begin
         old_value_ff <= old_value_in;
         free_slot_ff <= free_slot_in;
         occupied_ff  <= occupied_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_old_value = old_value_ff;
   assign rsp_free_slot = free_slot_ff;
   assign rsp_occupied  = occupied_ff;
   assign rsp_status    = status_ff;

   // Checks on the table bookkeeping and the sequencing.
   `SHT_ASSERT_NOW(a_count_matches_map, 1'b1, $countones(used_map_ff) == int'(used_total_ff), "occupied count disagrees with occupancy flags")
   `SHT_ASSERT_NEXT(a_xfer_starts_exec, req_xfer, state_ff == ST_EXEC, "request transfer did not start the execute cycle")
   `SHT_ASSERT_NEXT(a_done_gives_rsp, done, rsp_valid_ff && state_ff == ST_IDLE, "completed request produced no response")
   `SHT_ASSERT_NOW(a_no_write_when_idle, state_ff == ST_IDLE, !wr_en && used_map_in == used_map_ff, "table changed outside the execute cycle")

endmodule
